[design/ekm_pkg.sv]
// ----------------------------------------------------------------------------
// ekm_pkg
// Shared types, constants and the square-root step for the kernel entry pipe.
// ----------------------------------------------------------------------------
package ekm_pkg;

	localparam int DIM          = 3;
	localparam int COORD_W      = 16;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int SQ_W         = 2 * COORD_W + 1;
	localparam int SUM_W        = 34;
	localparam int ROOT_W       = 36;
	localparam int R_W          = 17;
	localparam int SQRT_STEPS   = 18;
	localparam int SQRT_PER_STG = 2;
	localparam int SQRT_STG     = SQRT_STEPS / SQRT_PER_STG;
	localparam int VAL_W        = 24;

	localparam logic [VAL_W-1:0] OUT_MAX   = 24'hFFFFFF;
	localparam logic [17:0]      LOG2E_Q16 = 18'd94548;
	localparam logic [15:0]      POLY_C1   = 16'd45554;
	localparam logic [13:0]      POLY_C2   = 14'd14824;
	localparam logic [12:0]      POLY_C3   = 13'd5158;
	localparam logic [17:0]      ONE_Q16   = 18'd65536;

	// config register indexes
	localparam logic [1:0] REG_INV_SCALE = 2'd0;
	localparam logic [1:0] REG_LOG_BIAS  = 2'd1;
	localparam logic [1:0] REG_DIMS_USED = 2'd2;

	typedef struct packed {
		logic [VAL_W-1:0] diag;
		logic             last;
	} side_t;

	typedef struct packed {
		logic [ROOT_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	// one restoring step of the integer square root
	function automatic sq_t sqrt_step(sq_t in, logic [ROOT_W-1:0] bitv);
		sq_t              o;
		logic [ROOT_W-1:0] trial;
		trial = in.root + bitv;
		if (in.rem >= trial) begin
			o.rem  = in.rem - trial;
			o.root = (in.root >> 1) + bitv;
		end else begin
			o.rem  = in.rem;
			o.root = in.root >> 1;
		end
		return o;
	endfunction

endpackage

[design/ekm_sqrt.sv]
// ----------------------------------------------------------------------------
// ekm_sqrt
// Pipelined integer square root, two restoring steps per register stage.
// ----------------------------------------------------------------------------
module ekm_sqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ekm_pkg::SUM_W-1:0]   sum_in,
	output logic [ekm_pkg::R_W-1:0]     root_out
);

	ekm_pkg::sq_t stg_q [ekm_pkg::SQRT_STG];

	for (genvar g = 0; g < ekm_pkg::SQRT_STG; g++) begin : g_stg
		ekm_pkg::sq_t a, b, src;
		localparam int B0 = 34 - 2 * (g * ekm_pkg::SQRT_PER_STG);
		localparam logic [ekm_pkg::ROOT_W-1:0] BIT0 = ekm_pkg::ROOT_W'(1) << B0;
		localparam logic [ekm_pkg::ROOT_W-1:0] BIT1 = ekm_pkg::ROOT_W'(1) << (B0 - 2);

		if (g == 0) begin : g_first
			assign src.rem  = ekm_pkg::ROOT_W'(sum_in);
			assign src.root = '0;
		end else begin : g_next
			assign src = stg_q[g-1];
		end

		always_comb begin
			a = ekm_pkg::sqrt_step(src, BIT0);
			b = ekm_pkg::sqrt_step(a, BIT1);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_q[g] <= b;
			end
		end
	end

	assign root_out = stg_q[ekm_pkg::SQRT_STG-1].root[ekm_pkg::R_W-1:0];

endmodule

[design/exponential_kernel_matrix_entry.sv]
// ----------------------------------------------------------------------------
// exponential_kernel_matrix_entry
// Exponential (Ornstein-Uhlenbeck) kernel entry for one point pair per transfer.
// ----------------------------------------------------------------------------
// One point pair enters per clock and its kernel entry leaves through the pipe
// (3 distance stages, 9 square-root stages at two root bits each, 7 exponent
// stages, then the output register). Throughput is one transfer per cycle; the
// whole pipe advances together whenever the output register is empty or being
// taken, so a stall at the output holds every stage in place. Result is
// exp(log_bias - r*inv_scale) + diag_add in unsigned Q8.16, clipped to
// 0xFFFFFF with the saturated flag in m_tuser. Configuration writes are meant
// for when the pipe is empty; registers feed the datapath directly.
// ----------------------------------------------------------------------------
module exponential_kernel_matrix_entry (
	input  logic         clk,
	input  logic         arst_n,
	// config
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [15:0]  cfg_wdata,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [119:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, diag_add
	input  logic         s_tlast,   // last_pair
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [23:0]  m_tdata,   // kernel_value
	output logic [0:0]   m_tuser,   // saturated
	output logic         m_tlast    // last_out
);

	localparam int PRE   = 3;
	localparam int POST  = 7;
	localparam int DEPTH = PRE + ekm_pkg::SQRT_STG + POST;

	// config registers
	logic [15:0] inv_scale_q;
	logic [15:0] log_bias_q;
	logic [1:0]  dims_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_scale_q <= 16'd256;
			log_bias_q  <= 16'd0;
			dims_used_q <= 2'd3;
		end else if (cfg_we) begin
			case (cfg_addr)
				ekm_pkg::REG_INV_SCALE: inv_scale_q <= cfg_wdata;
				ekm_pkg::REG_LOG_BIAS:  log_bias_q  <= cfg_wdata;
				ekm_pkg::REG_DIMS_USED: dims_used_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// global advance: output slot free or draining
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// valid and sideband travel together
	logic           vld_q  [DEPTH];
	ekm_pkg::side_t side_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= s_tvalid;
			for (int i = 1; i < DEPTH; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= '{diag: s_tdata[119:96], last: s_tlast};
			for (int i = 1; i < DEPTH; i++) side_q[i] <= side_q[i-1];
		end
	end

	// s1: coordinate differences, unused dims forced to zero
	logic signed [ekm_pkg::DIFF_W-1:0] d_s1 [ekm_pkg::DIM];
	logic signed [ekm_pkg::DIFF_W-1:0] d_c  [ekm_pkg::DIM];

	always_comb begin
		for (int k = 0; k < ekm_pkg::DIM; k++) begin
			d_c[k] = ekm_pkg::DIFF_W'($signed(s_tdata[16*k +: 16]))
				- ekm_pkg::DIFF_W'($signed(s_tdata[16*(k+3) +: 16]));
			if (!(k < int'(dims_used_q))) d_c[k] = '0;
		end
	end

	// s2: squares, s3: sum
	logic [ekm_pkg::SQ_W-1:0]  sq_s2 [ekm_pkg::DIM];
	logic [ekm_pkg::SUM_W-1:0] sum_s3;
	logic [ekm_pkg::SUM_W-1:0] sum_c;
	logic signed [2*ekm_pkg::DIFF_W-1:0] prod_c [ekm_pkg::DIM];

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < ekm_pkg::DIM; k++) begin
			prod_c[k] = d_s1[k] * d_s1[k];
			sum_c = sum_c + ekm_pkg::SUM_W'(sq_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ekm_pkg::DIM; k++) begin
				d_s1[k]  <= d_c[k];
				sq_s2[k] <= prod_c[k][ekm_pkg::SQ_W-1:0];
			end
			sum_s3 <= sum_c;
		end
	end

	// square root
	logic [ekm_pkg::R_W-1:0] r_root;

	ekm_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.sum_in   (sum_s3),
		.root_out (r_root)
	);

	// s4..s10: scale, bias, base change, 2^f polynomial, shift
	logic [32:0]        t_s4;
	logic signed [34:0] e_s5;
	logic signed [52:0] x_c;
	logic signed [20:0] n_s6, n_s7, n_s8, n_s9;
	logic [15:0]        f_s6, f_s7, f_s8;
	logic [28:0]        p1_s7;
	logic [31:0]        p2_s8;
	logic [32:0]        p3_s9;
	logic [15:0]        h2_c;
	logic [16:0]        h1_c;
	logic [17:0]        m_c;
	logic [24:0]        v_c, v_s10;
	logic               xs_c, xs_s10;

	localparam int LOG2E_W = 19;
	assign x_c  = e_s5 * $signed(LOG2E_W'(ekm_pkg::LOG2E_Q16));
	assign h2_c = 16'(ekm_pkg::POLY_C2) + 16'(p1_s7[28:16]);
	assign h1_c = 17'(ekm_pkg::POLY_C1) + 17'(p2_s8[31:16]);
	assign m_c  = ekm_pkg::ONE_Q16 + 18'(p3_s9[32:16]);

	always_comb begin
		xs_c = 1'b0;
		if (n_s9 >= 21'sd8) begin
			v_c  = 25'(ekm_pkg::OUT_MAX);
			xs_c = 1'b1;
		end else if (n_s9 >= 21'sd0) begin
			v_c = 25'(m_c) << n_s9[2:0];
		end else if (n_s9 > -21'sd32) begin
			v_c = 25'(m_c >> (-n_s9[5:0]));
		end else begin
			v_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4   <= r_root * inv_scale_q;
			e_s5   <= 35'($signed({log_bias_q, 8'b0})) - $signed({2'b0, t_s4});
			n_s6   <= x_c[52:32];
			f_s6   <= x_c[31:16];
			p1_s7  <= ekm_pkg::POLY_C3 * f_s6;
			n_s7   <= n_s6;
			f_s7   <= f_s6;
			p2_s8  <= h2_c * f_s7;
			n_s8   <= n_s7;
			f_s8   <= f_s7;
			p3_s9  <= h1_c * f_s8;
			n_s9   <= n_s8;
			v_s10  <= v_c;
			xs_s10 <= xs_c;
		end
	end

	// output register: add noise term and clip
	logic [25:0] tot_c;
	assign tot_c = 26'(v_s10) + 26'(side_q[DEPTH-1].diag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_q[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tlast <= side_q[DEPTH-1].last;
			if (tot_c > 26'(ekm_pkg::OUT_MAX)) begin
				m_tdata <= ekm_pkg::OUT_MAX;
				m_tuser <= 1'b1;
			end else begin
				m_tdata <= tot_c[23:0];
				m_tuser <= xs_s10;
			end
		end
	end

	// checks
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		en && s_tvalid |=> vld_q[0])
		else $error("accepted transfer not captured in first stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_q[DEPTH-1] == $past(vld_q[DEPTH-1]) && vld_q[0] == $past(vld_q[0]))
		else $error("pipe moved during stall");

	a_exit: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_q[DEPTH-1] |=> m_tvalid)
		else $error("result lost at output register");

	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata != ekm_pkg::OUT_MAX |-> !m_tuser[0])
		else $error("saturated flag on unclipped value");

endmodule
